[design/m3inv_pkg.sv]
// ----------------------------------------------------------------------------
// m3inv_pkg
// Widths, transfer types and a saturating helper for the 3x3 cofactor inverse pipeline.
// ----------------------------------------------------------------------------
package m3inv_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int TOL_BITS  = 31;

   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int ADJ_BITS  = PROD_BITS + 1;
   localparam int LO_BITS   = WORD_BITS;
   localparam int HI_BITS   = ADJ_BITS - LO_BITS;
   localparam int PLO_BITS  = WORD_BITS + LO_BITS + 1;
   localparam int PHI_BITS  = WORD_BITS + HI_BITS;
   localparam int TERM_BITS = WORD_BITS + ADJ_BITS;
   localparam int DET_BITS  = TERM_BITS + 2;
   localparam int QUO_BITS  = WORD_BITS;
   localparam int REM_BITS  = DET_BITS + QUO_BITS;
   localparam int DIV_STAGES = QUO_BITS;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] a00;
      logic signed [WORD_BITS-1:0] a01;
      logic signed [WORD_BITS-1:0] a02;
      logic signed [WORD_BITS-1:0] a10;
      logic signed [WORD_BITS-1:0] a11;
      logic signed [WORD_BITS-1:0] a12;
      logic signed [WORD_BITS-1:0] a20;
      logic signed [WORD_BITS-1:0] a21;
      logic signed [WORD_BITS-1:0] a22;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] q00;
      logic signed [WORD_BITS-1:0] q01;
      logic signed [WORD_BITS-1:0] q02;
      logic signed [WORD_BITS-1:0] q10;
      logic signed [WORD_BITS-1:0] q11;
      logic signed [WORD_BITS-1:0] q12;
      logic signed [WORD_BITS-1:0] q20;
      logic signed [WORD_BITS-1:0] q21;
      logic signed [WORD_BITS-1:0] q22;
      logic                        invertible;
   } rsp_type;

   // sign/magnitude to a saturated two's complement word
   function automatic logic [WORD_BITS-1:0] sat_word(input logic neg,
                                                     input logic [ADJ_BITS-1:0] m);
      logic [ADJ_BITS-1:0] lim;
      logic [WORD_BITS-1:0] res;
      lim = ADJ_BITS'(1) << (WORD_BITS - 1);
      if (neg) begin
         if (m > lim) res = lim[WORD_BITS-1:0];
         else res = WORD_BITS'(~m + ADJ_BITS'(1));
      end else begin
         if (m >= lim) res = {1'b0, {(WORD_BITS-1){1'b1}}};
         else res = m[WORD_BITS-1:0];
      end
      return res;
   endfunction

endpackage

[design/matrix3_inverse_cofactor.sv]
// Throughput: one matrix per cycle; the whole pipeline holds while a result waits.
// The divider is 32 restoring stages, one quotient bit each, nine entries wide.
// Reset clears all valid bits and the tolerance register; data registers are not reset.
// ----------------------------------------------------------------------------
// matrix3_inverse_cofactor
// Pipelined 3x3 inverse by adjugate and first-row determinant, Q16.16.
// ----------------------------------------------------------------------------
module matrix3_inverse_cofactor (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  m3inv_pkg::req_type                 req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output m3inv_pkg::rsp_type                 rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [m3inv_pkg::TOL_BITS-1:0]     csr_data
);

   localparam int W   = m3inv_pkg::WORD_BITS;
   localparam int F   = m3inv_pkg::FRAC_BITS;
   localparam int PB  = m3inv_pkg::PROD_BITS;
   localparam int AB  = m3inv_pkg::ADJ_BITS;
   localparam int LB  = m3inv_pkg::LO_BITS;
   localparam int PLB = m3inv_pkg::PLO_BITS;
   localparam int PHB = m3inv_pkg::PHI_BITS;
   localparam int TB  = m3inv_pkg::TERM_BITS;
   localparam int DB  = m3inv_pkg::DET_BITS;
   localparam int QB  = m3inv_pkg::QUO_BITS;
   localparam int RB  = m3inv_pkg::REM_BITS;
   localparam int DS  = m3inv_pkg::DIV_STAGES;

   logic adv;
   logic [m3inv_pkg::TOL_BITS-1:0] tol_ff;

   // stage 1: input
   logic                s1_v_ff;
   logic signed [W-1:0] s1_a_ff [9];
   // stage 2: products
   logic                 s2_v_ff;
   logic signed [PB-1:0] s2_pp_ff [9];
   logic signed [PB-1:0] s2_pn_ff [9];
   logic signed [PB-1:0] s2_pp_in [9];
   logic signed [PB-1:0] s2_pn_in [9];
   logic signed [W-1:0]  s2_r0_ff [3];
   // stage 3: adjugate
   logic                 s3_v_ff;
   logic signed [AB-1:0] s3_adj_ff [9];
   logic signed [W-1:0]  s3_r0_ff [3];
   // stage 4: determinant partial products
   logic                  s4_v_ff;
   logic signed [AB-1:0]  s4_adj_ff [9];
   logic signed [PLB-1:0] s4_plo_ff [3];
   logic signed [PHB-1:0] s4_phi_ff [3];
   logic signed [PLB-1:0] s4_plo_in [3];
   logic signed [PHB-1:0] s4_phi_in [3];
   // stage 5: terms
   logic                 s5_v_ff;
   logic signed [AB-1:0] s5_adj_ff [9];
   logic signed [TB-1:0] s5_term_ff [3];
   // stage 6: determinant
   logic                 s6_v_ff;
   logic signed [AB-1:0] s6_adj_ff [9];
   logic signed [DB-1:0] s6_det_ff;
   // stage 7: magnitudes
   logic          s7_v_ff;
   logic [DB-1:0] s7_mag_ff;
   logic          s7_dneg_ff;
   logic          s7_ok_ff;
   logic [AB-1:0] s7_amag_ff [9];
   logic          s7_aneg_ff [9];
   logic [DB-1:0] s7_mag_in;
   logic [AB-1:0] s7_amag_in [9];
   logic          s7_aneg_in [9];
   // divider chain; index 0 is the set-up stage
   logic          dv_v_ff   [DS+1];
   logic [DB-1:0] dv_mag_ff [DS+1];
   logic          dv_ok_ff  [DS+1];
   logic [RB-1:0] dv_r_ff   [DS+1][9];
   logic [QB-1:0] dv_q_ff   [DS+1][9];
   logic          dv_neg_ff [DS+1][9];
   logic          dv_ovf_ff [DS+1][9];
   logic [W-1:0]  dv_sw_ff  [DS+1][9];
   logic [RB-1:0] dv_r_in   [DS+1][9];
   logic [QB-1:0] dv_q_in   [DS+1][9];
   logic          dv_ovf_in [9];
   logic [W-1:0]  dv_sw_in  [9];
   logic [AB-1:0] rnd       [9];
   // output
   logic               rsp_valid_ff;
   m3inv_pkg::rsp_type rsp_data_ff;
   m3inv_pkg::rsp_type rsp_data_in;
   logic [W-1:0]       res_w [9];
   logic               rem_ok;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_valid) begin
         tol_ff <= csr_data;
      end
   end

   // products of the adjugate pairs
   always_comb begin
      s2_pp_in[0] = s1_a_ff[4] * s1_a_ff[8];  s2_pn_in[0] = s1_a_ff[5] * s1_a_ff[7];
      s2_pp_in[1] = s1_a_ff[2] * s1_a_ff[7];  s2_pn_in[1] = s1_a_ff[1] * s1_a_ff[8];
      s2_pp_in[2] = s1_a_ff[1] * s1_a_ff[5];  s2_pn_in[2] = s1_a_ff[2] * s1_a_ff[4];
      s2_pp_in[3] = s1_a_ff[5] * s1_a_ff[6];  s2_pn_in[3] = s1_a_ff[3] * s1_a_ff[8];
      s2_pp_in[4] = s1_a_ff[0] * s1_a_ff[8];  s2_pn_in[4] = s1_a_ff[2] * s1_a_ff[6];
      s2_pp_in[5] = s1_a_ff[2] * s1_a_ff[3];  s2_pn_in[5] = s1_a_ff[0] * s1_a_ff[5];
      s2_pp_in[6] = s1_a_ff[3] * s1_a_ff[7];  s2_pn_in[6] = s1_a_ff[4] * s1_a_ff[6];
      s2_pp_in[7] = s1_a_ff[1] * s1_a_ff[6];  s2_pn_in[7] = s1_a_ff[0] * s1_a_ff[7];
      s2_pp_in[8] = s1_a_ff[0] * s1_a_ff[4];  s2_pn_in[8] = s1_a_ff[1] * s1_a_ff[3];
   end

   // det = sum a0j * adj[j][0], each split into low and high halves
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         s4_plo_in[j] = s3_r0_ff[j] * $signed({1'b0, s3_adj_ff[3*j][LB-1:0]});
         s4_phi_in[j] = s3_r0_ff[j] * $signed(s3_adj_ff[3*j][AB-1:LB]);
      end
   end

   always_comb begin
      s7_mag_in = s6_det_ff[DB-1] ? DB'(-s6_det_ff) : DB'(s6_det_ff);
      for (int i = 0; i < 9; i++) begin
         s7_aneg_in[i] = s6_adj_ff[i][AB-1];
         s7_amag_in[i] = s6_adj_ff[i][AB-1] ? AB'(-s6_adj_ff[i]) : AB'(s6_adj_ff[i]);
      end
   end

   // divider set-up, singular-path rounding and one quotient bit per stage
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         dv_r_in[0][i] = (RB'(s7_amag_ff[i]) << (2 * F)) + RB'(s7_mag_ff >> 1);
         dv_q_in[0][i] = '0;
         dv_ovf_in[i]  = dv_r_in[0][i] >= (RB'(s7_mag_ff) << QB);
         rnd[i]        = (s7_amag_ff[i] + (AB'(1) << (F - 1))) >> F;
         dv_sw_in[i]   = m3inv_pkg::sat_word(s7_aneg_ff[i], rnd[i]);
      end
      for (int k = 0; k < DS; k++) begin
         for (int i = 0; i < 9; i++) begin
            if (dv_r_ff[k][i] >= (RB'(dv_mag_ff[k]) << (QB - 1 - k))) begin
               dv_r_in[k+1][i] = dv_r_ff[k][i] - (RB'(dv_mag_ff[k]) << (QB - 1 - k));
               dv_q_in[k+1][i] = dv_q_ff[k][i] | (QB'(1) << (QB - 1 - k));
            end else begin
               dv_r_in[k+1][i] = dv_r_ff[k][i];
               dv_q_in[k+1][i] = dv_q_ff[k][i];
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         if (!dv_ok_ff[DS]) begin
            res_w[i] = dv_sw_ff[DS][i];
         end else if (dv_ovf_ff[DS][i]) begin
            res_w[i] = m3inv_pkg::sat_word(dv_neg_ff[DS][i], AB'(1) << W);
         end else begin
            res_w[i] = m3inv_pkg::sat_word(dv_neg_ff[DS][i], AB'(dv_q_ff[DS][i]));
         end
      end
      rsp_data_in.q00 = res_w[0];
      rsp_data_in.q01 = res_w[1];
      rsp_data_in.q02 = res_w[2];
      rsp_data_in.q10 = res_w[3];
      rsp_data_in.q11 = res_w[4];
      rsp_data_in.q12 = res_w[5];
      rsp_data_in.q20 = res_w[6];
      rsp_data_in.q21 = res_w[7];
      rsp_data_in.q22 = res_w[8];
      rsp_data_in.invertible = dv_ok_ff[DS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
         s7_v_ff <= 1'b0;
         for (int k = 0; k <= DS; k++) dv_v_ff[k] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
         s6_v_ff <= s5_v_ff;
         s7_v_ff <= s6_v_ff;
         dv_v_ff[0] <= s7_v_ff;
         for (int k = 0; k < DS; k++) dv_v_ff[k+1] <= dv_v_ff[k];
         rsp_valid_ff <= dv_v_ff[DS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_a_ff[0] <= req_data.a00;
         s1_a_ff[1] <= req_data.a01;
         s1_a_ff[2] <= req_data.a02;
         s1_a_ff[3] <= req_data.a10;
         s1_a_ff[4] <= req_data.a11;
         s1_a_ff[5] <= req_data.a12;
         s1_a_ff[6] <= req_data.a20;
         s1_a_ff[7] <= req_data.a21;
         s1_a_ff[8] <= req_data.a22;
         for (int i = 0; i < 9; i++) begin
            s2_pp_ff[i]  <= s2_pp_in[i];
            s2_pn_ff[i]  <= s2_pn_in[i];
            s3_adj_ff[i] <= AB'(s2_pp_ff[i]) - AB'(s2_pn_ff[i]);
            s4_adj_ff[i] <= s3_adj_ff[i];
            s5_adj_ff[i] <= s4_adj_ff[i];
            s6_adj_ff[i] <= s5_adj_ff[i];
            s7_amag_ff[i] <= s7_amag_in[i];
            s7_aneg_ff[i] <= s7_aneg_in[i];
            dv_r_ff[0][i]   <= dv_r_in[0][i];
            dv_q_ff[0][i]   <= dv_q_in[0][i];
            dv_neg_ff[0][i] <= s7_aneg_ff[i] ^ s7_dneg_ff;
            dv_ovf_ff[0][i] <= dv_ovf_in[i];
            dv_sw_ff[0][i]  <= dv_sw_in[i];
         end
         for (int j = 0; j < 3; j++) begin
            s2_r0_ff[j]   <= s1_a_ff[j];
            s3_r0_ff[j]   <= s2_r0_ff[j];
            s4_plo_ff[j]  <= s4_plo_in[j];
            s4_phi_ff[j]  <= s4_phi_in[j];
            s5_term_ff[j] <= (TB'(s4_phi_ff[j]) <<< LB) + TB'(s4_plo_ff[j]);
         end
         s6_det_ff  <= DB'(s5_term_ff[0]) + DB'(s5_term_ff[1]) + DB'(s5_term_ff[2]);
         s7_mag_ff  <= s7_mag_in;
         s7_dneg_ff <= s6_det_ff[DB-1];
         s7_ok_ff   <= s7_mag_in > (DB'(tol_ff) << (2 * F));
         dv_mag_ff[0] <= s7_mag_ff;
         dv_ok_ff[0]  <= s7_ok_ff;
         for (int k = 0; k < DS; k++) begin
            dv_mag_ff[k+1] <= dv_mag_ff[k];
            dv_ok_ff[k+1]  <= dv_ok_ff[k];
            for (int i = 0; i < 9; i++) begin
               dv_r_ff[k+1][i]   <= dv_r_in[k+1][i];
               dv_q_ff[k+1][i]   <= dv_q_in[k+1][i];
               dv_neg_ff[k+1][i] <= dv_neg_ff[k][i];
               dv_ovf_ff[k+1][i] <= dv_ovf_ff[k][i];
               dv_sw_ff[k+1][i]  <= dv_sw_ff[k][i];
            end
         end
         rsp_data_ff <= rsp_data_in;
      end
   end

   // saturating lanes leave a remainder at or above the divisor
   always_comb begin
      rem_ok = 1'b1;
      for (int i = 0; i < 9; i++) begin
         if (!dv_ovf_ff[DS][i] && dv_r_ff[DS][i] >= RB'(dv_mag_ff[DS])) rem_ok = 1'b0;
      end
   end

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_v_ff)
      else $error("transfer not captured in first stage");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(dv_v_ff[DS]) && $stable(s1_v_ff))
      else $error("pipeline moved during stall");

   a_zero_det_singular: assert property (@(posedge clock) disable iff (reset)
      s7_v_ff && s7_mag_ff == '0 |-> !s7_ok_ff)
      else $error("zero determinant marked invertible");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      dv_v_ff[DS] && dv_ok_ff[DS] |-> rem_ok)
      else $error("divider remainder not below divisor");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(dv_v_ff[DS]))
      else $error("result without item in last divider stage");

endmodule
